FILE: design/pks_pkg.sv
// ----------------------------------------------------------------------------
// pks_pkg
// Shared types and constants of the port knock sequence tracker: request and
// response words, configuration set, table entry layout and code values.
// ----------------------------------------------------------------------------
package pks_pkg;

  localparam int unsigned PORT_W        = 16;
  localparam int unsigned IP_W          = 32;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned STEP_W        = 2;
  localparam int unsigned LEN_W         = 3;
  localparam int unsigned TMO_W         = 16;
  localparam int unsigned DEDUP_W       = 8;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned COUNT_W       = 7;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned NUM_SEQ_PORTS = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // knock status codes
  localparam logic [STATUS_W-1:0] STATUS_IDLE     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_PROGRESS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_COMPLETE = 2'd2;

  // request types
  localparam logic REQ_KNOCK = 1'b0;
  localparam logic REQ_SWEEP = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_PORT_0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_PORT_1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_PORT_2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_PORT_3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KNOCK_TIMEOUT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEDUP_WINDOW  = 3'd6;

  typedef struct packed {
    logic              req_type;
    logic [IP_W-1:0]   source_ip;
    logic [PORT_W-1:0] dest_port;
    logic [TIME_W-1:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] knock_status;
    logic [COUNT_W-1:0]  entries_cleared;
  } rsp_t;

  typedef struct packed {
    logic [NUM_SEQ_PORTS-1:0][PORT_W-1:0] seq_port;
    logic [LEN_W-1:0]                     seq_length;
    logic [TMO_W-1:0]                     knock_timeout;
    logic [DEDUP_W-1:0]                   dedup_window;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              prev_valid;
    logic [IP_W-1:0]   address;
    logic [STEP_W-1:0] step;
    logic [TIME_W-1:0] stamp;
    logic [PORT_W-1:0] prev_port;
  } entry_t;

  typedef struct packed {
    logic idle;
    logic rsp_valid;
    rsp_t rsp;
  } eng_stat_t;

endpackage

FILE: design/port_knock_sequence_tracker_top.sv
// ----------------------------------------------------------------------------
// port_knock_sequence_tracker_top
// One request at a time: input is stalled from accept until the result word
//   is taken into the output register, after a scan that reads one client
//   table entry per cycle over the RAM read port.
// Reset: control registers take their reset values at once; a clearing pass
//   over every table entry then empties the table while input is stalled.
// ----------------------------------------------------------------------------
module port_knock_sequence_tracker_top #(
  parameter int unsigned TABLE_DEPTH  = 64,
  parameter int unsigned MAX_SEQUENCE = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pks_pkg::CFG_IDX_W-1:0]       cfg_addr_i,
  input  logic [pks_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  pks_pkg::req_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output pks_pkg::rsp_t                       out_data_o
);

  import pks_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  cfg_t      cfg_q;
  eng_stat_t eng_stat;
  logic      rsp_ready;
  logic      out_valid_q, out_valid_d;
  rsp_t      out_data_q;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seq_port      <= '0;
      cfg_q.seq_length    <= LEN_W'(3);
      cfg_q.knock_timeout <= TMO_W'(10);
      cfg_q.dedup_window  <= DEDUP_W'(5);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_SEQ_PORT_0:    cfg_q.seq_port[0]   <= cfg_wdata_i;
        REG_SEQ_PORT_1:    cfg_q.seq_port[1]   <= cfg_wdata_i;
        REG_SEQ_PORT_2:    cfg_q.seq_port[2]   <= cfg_wdata_i;
        REG_SEQ_PORT_3:    cfg_q.seq_port[3]   <= cfg_wdata_i;
        REG_SEQ_LENGTH:    cfg_q.seq_length    <= cfg_wdata_i[LEN_W-1:0];
        REG_KNOCK_TIMEOUT: cfg_q.knock_timeout <= cfg_wdata_i[TMO_W-1:0];
        REG_DEDUP_WINDOW:  cfg_q.dedup_window  <= cfg_wdata_i[DEDUP_W-1:0];
        default: ;
      endcase
    end
  end

  pks_engine #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .MAX_SEQUENCE (MAX_SEQUENCE)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .rsp_ready_i (rsp_ready),
    .stat_o      (eng_stat),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  pks_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = !eng_stat.idle;

  // output register frees the engine once the word is taken
  assign rsp_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (eng_stat.rsp_valid && rsp_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_stat.rsp_valid && rsp_ready) begin
      out_data_q <= eng_stat.rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another is in flight");

  a_pending_is_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_stat.rsp_valid |-> in_stall_o)
    else $error("input open while a result is pending");

  a_knock_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.knock_status != STATUS_IDLE |->
      out_data_o.entries_cleared == '0)
    else $error("knock result carries a cleared count");

endmodule

FILE: design/pks_ram.sv
// ----------------------------------------------------------------------------
// pks_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module pks_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/pks_engine.sv
// ----------------------------------------------------------------------------
// pks_engine
// Request sequencer: clears the client table after reset, scans every entry
// once per request (match, first free slot, oldest slot, stale entries) and
// writes back the updated entry after a knock unless it was a miss or a dedup.
// ----------------------------------------------------------------------------
module pks_engine #(
  parameter int unsigned TABLE_DEPTH  = 64,
  parameter int unsigned MAX_SEQUENCE = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pks_pkg::cfg_t                  cfg_i,
  input  logic                           in_valid_i,
  input  pks_pkg::req_t                  in_data_i,
  input  logic                           rsp_ready_i,
  output pks_pkg::eng_stat_t             stat_o,
  output logic                           ram_we_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr_o,
  output pks_pkg::entry_t                ram_wdata_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr_o,
  input  pks_pkg::entry_t                ram_rdata_i
);

  import pks_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_SEQUENCE);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [IDX_W-1:0]   addr_q, addr_d;
  logic               issue_q, issue_d;
  logic               rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  req_t               req_q, req_d;
  logic               found_q, found_d;
  logic [IDX_W-1:0]   match_idx_q, match_idx_d;
  entry_t             match_q, match_d;
  logic               free_found_q, free_found_d;
  logic [IDX_W-1:0]   free_idx_q, free_idx_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  logic [TIME_W-1:0]  best_age_q, best_age_d;
  logic [COUNT_W-1:0] cleared_q, cleared_d;

  logic [TIME_W-1:0]  scan_age;
  logic [TIME_W-1:0]  timeout_ext;

  // knock resolution
  entry_t             cur;
  entry_t             upd;
  logic [IDX_W-1:0]   tgt_idx;
  logic [TIME_W-1:0]  cur_age;
  logic               miss;
  logic               dedup;
  logic [STEP_W-1:0]  step_eff;
  logic [LEN_W-1:0]   step_next;
  logic [LEN_W-1:0]   eff_len;
  logic               knock_we;
  logic [STATUS_W-1:0] knock_status;

  assign timeout_ext = TIME_W'(cfg_i.knock_timeout);
  assign scan_age    = req_q.now_seconds - ram_rdata_i.stamp;

  always_comb begin
    if (cfg_i.seq_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (cfg_i.seq_length > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = cfg_i.seq_length;
    end
  end

  always_comb begin
    // unknown client opens a fresh entry in the free or oldest slot
    if (found_q) begin
      cur     = match_q;
      tgt_idx = match_idx_q;
    end else begin
      cur.valid      = 1'b1;
      cur.prev_valid = 1'b0;
      cur.address    = req_q.source_ip;
      cur.step       = '0;
      cur.stamp      = req_q.now_seconds;
      cur.prev_port  = '0;
      tgt_idx        = free_found_q ? free_idx_q : best_idx_q;
    end
    miss    = !found_q && (req_q.dest_port != cfg_i.seq_port[0]);
    cur_age = req_q.now_seconds - cur.stamp;
    dedup   = cur.prev_valid && (req_q.dest_port == cur.prev_port) &&
              (cur_age <= TIME_W'(cfg_i.dedup_window));
    step_eff = cur.step;
    if ((cur.step != '0) && (cur_age > timeout_ext)) begin
      step_eff = '0;
    end
    step_next = LEN_W'(step_eff) + LEN_W'(1);
    upd       = cur;
    if (req_q.dest_port == cfg_i.seq_port[step_eff]) begin
      upd.step       = step_next[STEP_W-1:0];
      upd.stamp      = req_q.now_seconds;
      upd.prev_port  = req_q.dest_port;
      upd.prev_valid = 1'b1;
      upd.valid      = (step_next < eff_len);
      knock_status   = (step_next < eff_len) ? STATUS_PROGRESS : STATUS_COMPLETE;
    end else if (req_q.dest_port == cfg_i.seq_port[0]) begin
      // restart at step 1, remembered port stays
      upd.step     = STEP_W'(1);
      upd.stamp    = req_q.now_seconds;
      knock_status = STATUS_PROGRESS;
    end else begin
      upd.step     = step_eff;
      upd.valid    = 1'b0;
      knock_status = STATUS_IDLE;
    end
    knock_we = 1'b1;
    if (miss) begin
      knock_status = STATUS_IDLE;
      knock_we     = 1'b0;
    end else if (dedup) begin
      knock_status = STATUS_PROGRESS;
      knock_we     = 1'b0;
    end
  end

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    issue_d      = issue_q;
    rd_vld_d     = (state_q == ST_SCAN) && issue_q;
    rd_idx_d     = addr_q;
    req_d        = req_q;
    found_d      = found_q;
    match_idx_d  = match_idx_q;
    match_d      = match_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    best_idx_d   = best_idx_q;
    best_age_d   = best_age_q;
    cleared_d    = cleared_q;
    ram_we_o     = 1'b0;
    ram_waddr_o  = addr_q;
    ram_wdata_o  = '0;
    stat_o.idle      = (state_q == ST_IDLE);
    stat_o.rsp_valid = 1'b0;
    stat_o.rsp.knock_status    = STATUS_IDLE;
    stat_o.rsp.entries_cleared = '0;

    case (state_q)
      ST_CLEAR: begin
        ram_we_o = 1'b1;
        addr_d   = addr_q + IDX_W'(1);
        if (addr_q == LAST_IDX) begin
          addr_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d        = in_data_i;
          state_d      = ST_SCAN;
          addr_d       = '0;
          issue_d      = 1'b1;
          found_d      = 1'b0;
          free_found_d = 1'b0;
          cleared_d    = '0;
        end
      end
      ST_SCAN: begin
        if (issue_q) begin
          addr_d = addr_q + IDX_W'(1);
          if (addr_q == LAST_IDX) begin
            addr_d  = '0;
            issue_d = 1'b0;
          end
        end
        if (rd_vld_q) begin
          if (req_q.req_type == REQ_SWEEP) begin
            // drop stale entries; read runs one address ahead of the write
            if (ram_rdata_i.valid && (scan_age > timeout_ext)) begin
              ram_we_o          = 1'b1;
              ram_waddr_o       = rd_idx_q;
              ram_wdata_o       = ram_rdata_i;
              ram_wdata_o.valid = 1'b0;
              if (cleared_q != COUNT_MAX) begin
                cleared_d = cleared_q + COUNT_W'(1);
              end
            end
          end else begin
            if (!found_q && ram_rdata_i.valid &&
                (ram_rdata_i.address == req_q.source_ip)) begin
              found_d     = 1'b1;
              match_idx_d = rd_idx_q;
              match_d     = ram_rdata_i;
            end
            if (!free_found_q && !ram_rdata_i.valid) begin
              free_found_d = 1'b1;
              free_idx_d   = rd_idx_q;
            end
            if ((rd_idx_q == '0) || (scan_age > best_age_q)) begin
              best_idx_d = rd_idx_q;
              best_age_d = scan_age;
            end
          end
          if (rd_idx_q == LAST_IDX) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        stat_o.rsp_valid = 1'b1;
        if (req_q.req_type == REQ_SWEEP) begin
          stat_o.rsp.entries_cleared = cleared_q;
        end else begin
          stat_o.rsp.knock_status = knock_status;
        end
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
          if (req_q.req_type == REQ_KNOCK && knock_we) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = tgt_idx;
            ram_wdata_o = upd;
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
        addr_d  = '0;
      end
    endcase
  end

  assign ram_raddr_o = addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      addr_q       <= '0;
      issue_q      <= 1'b0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      cleared_q    <= '0;
    end else begin
      state_q      <= state_d;
      addr_q       <= addr_d;
      issue_q      <= issue_d;
      rd_vld_q     <= rd_vld_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
      cleared_q    <= cleared_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    req_q       <= req_d;
    match_idx_q <= match_idx_d;
    match_q     <= match_d;
    free_idx_q  <= free_idx_d;
    best_idx_q  <= best_idx_d;
    best_age_q  <= best_age_d;
  end

endmodule
